### design/glzw_pkg.sv
// shared constants, types and helper functions of the gif lzw pixel decoder
package glzw_pkg;

	localparam int DICT_ENTRIES    = 4096;
	localparam int DICT_AW         = 12;
	localparam int MAX_CODE_BITS   = 12;
	localparam int GROUP_PIXELS    = 32;
	localparam int GROUP_AW        = 5;
	localparam int MAX_RESULTS     = 34;
	localparam int STACK_DEPTH_DEF = 1025;
	localparam int CFG_AW          = 2;
	localparam int CFG_DW          = 16;

	typedef enum logic [CFG_AW-1:0] {
		CFG_MIN_CODE_SIZE = 2'd0,
		CFG_COLOR_BITS    = 2'd1,
		CFG_IMAGE_WIDTH   = 2'd2,
		CFG_IMAGE_HEIGHT  = 2'd3
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NEXT,
		ST_WALK_RD,
		ST_WALK,
		ST_FINAL,
		ST_DELIVER,
		ST_CHECK,
		ST_POP_RD,
		ST_POP,
		ST_PUT_FULL,
		ST_POST,
		ST_PUT_LAST
	} state_t;

	function automatic logic [3:0] eff_min(input logic [3:0] m);
		if (m < 4'd2) return 4'd2;
		if (m > 4'd8) return 4'd8;
		return m;
	endfunction

	function automatic logic [3:0] eff_bits(input logic [3:0] b);
		if (b < 4'd1) return 4'd1;
		if (b > 4'd8) return 4'd8;
		return b;
	endfunction

	// low ones for a code of the given size
	function automatic logic [11:0] code_mask(input logic [3:0] size);
		logic [12:0] one_hot;
		one_hot = 13'd1 << size;
		return 12'(one_hot - 13'd1);
	endfunction

endpackage

### design/glzw_if.sv
// valid/ready channels for compressed bytes and packed pixel results
interface glzw_raster_if;
	logic       valid;
	logic       ready;
	logic [7:0] raster_byte;
	logic       start_image;

	modport source (output valid, output raster_byte, output start_image, input ready);
	modport sink   (input valid, input raster_byte, input start_image, output ready);
endinterface

interface glzw_pixel_if;
	logic        valid;
	logic        ready;
	logic [63:0] pixels_group_a;
	logic [63:0] pixels_group_b;
	logic [63:0] pixels_group_c;
	logic [63:0] pixels_group_d;
	logic [5:0]  pixel_count;
	logic        last_of_run;
	logic        end_of_image;
	logic        error_code;

	modport source (output valid, output pixels_group_a, output pixels_group_b,
		output pixels_group_c, output pixels_group_d, output pixel_count,
		output last_of_run, output end_of_image, output error_code, input ready);
	modport sink   (input valid, input pixels_group_a, input pixels_group_b,
		input pixels_group_c, input pixels_group_d, input pixel_count,
		input last_of_run, input end_of_image, input error_code, output ready);
endinterface

### design/glzw_ram.sv
// simple dual port ram, one write and one registered read per cycle
module glzw_ram #(
	parameter int W     = 8,
	parameter int DEPTH = glzw_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### design/gif_lzw_pixel_decoder.sv
// gif lzw pixel decoder: code gathering, dictionary walk and pixel packing
// Usage:
// raster channel takes one compressed byte per item; start_image set on an
// item reinitializes the decoder before that byte is used.
// pixels channel gives results of up to 32 pixel indices, first pixel in
// the low byte of pixels_group_a; the last result of every byte has
// last_of_run set and carries end_of_image or error_code.
// configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Sequence:
// a byte that completes no code is accepted, checked for a code and closed by
// its final result; a clear or end code adds a code check; any other code adds
// code check, first character, result accounting, stack read setup and
// dictionary update, a read setup and the entry walk when it walks the
// dictionary, and the pop of each pixel; with no pixel kept the stack read
// setup is skipped; a full group adds its put, plus a read setup if any remain.
// raster.ready is high only between bytes; the next byte is taken while
// the final result of the previous one waits in the output register.
// if pixels.ready stays low the decoder holds at its next result.
// reset clears the decoder to the just-cleared state with default
// registers; dictionary and stack need no clearing.
module gif_lzw_pixel_decoder #(
	parameter int STACK_DEPTH = glzw_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	glzw_raster_if.sink              raster,
	glzw_pixel_if.source             pixels,
	input  logic                     cfg_we,
	input  logic [glzw_pkg::CFG_AW-1:0] cfg_index,
	input  logic [glzw_pkg::CFG_DW-1:0] cfg_data
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int BW = CW + 2;

	glzw_pkg::state_t state_q, state_d;

	logic [3:0]  min_code_size_q, color_bits_q;
	logic [15:0] image_width_q, image_height_q;
	logic [31:0] total_q;

	logic [19:0] acc_q;
	logic [4:0]  held_q;
	logic [3:0]  size_q;
	logic [12:0] nfc_q;
	logic [11:0] prev_q, code_q, cur_q;
	logic [7:0]  fc_q;
	logic        after_clear_q, finished_q, lit_q;
	logic [31:0] written_q;
	logic [CW-1:0] cnt_q, kept_q, rem_q;
	logic [AW-1:0] ptr_q;
	logic [5:0]  fill_q, res_count_q;
	logic        eoi_f_q, err_f_q;
	logic [glzw_pkg::GROUP_PIXELS-1:0][7:0] group_q, out_group_q;
	logic        out_valid_q, out_last_q, out_eoi_q, out_err_q;
	logic [5:0]  out_count_q;

	logic        dict_we, stk_we;
	logic [11:0] dict_waddr, dict_raddr;
	logic [19:0] dict_wdata, dict_rdata;
	logic [AW-1:0] stk_waddr, stk_raddr;
	logic [7:0]  stk_wdata, stk_rdata;

	logic [3:0]  m_eff;
	logic [11:0] clear_code, lit_mask, code, start_cur, prefix;
	logic        accept, out_free, out_load, have_code, is_clear, is_eoi, kwk, stack_full;
	logic [BW-1:0] bud_sum;
	logic        bud_fail;
	logic [31:0] avail;
	logic [12:0] nfc_new;

	glzw_ram #(.W(20), .DEPTH(glzw_pkg::DICT_ENTRIES)) u_dict (
		.clk(clk), .we(dict_we), .waddr(dict_waddr), .wdata(dict_wdata),
		.raddr(dict_raddr), .rdata(dict_rdata)
	);

	glzw_ram #(.W(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign accept   = raster.valid && raster.ready;
	assign raster.ready = (state_q == glzw_pkg::ST_IDLE);
	assign out_free = !out_valid_q || pixels.ready;
	assign out_load = ((state_q == glzw_pkg::ST_PUT_FULL) || (state_q == glzw_pkg::ST_PUT_LAST))
		&& out_free;

	assign m_eff      = glzw_pkg::eff_min(min_code_size_q);
	assign clear_code = 12'd1 << m_eff;
	assign lit_mask   = {4'd0, 8'(glzw_pkg::code_mask(glzw_pkg::eff_bits(color_bits_q)))};
	assign have_code  = !finished_q && (held_q >= {1'b0, size_q});
	assign code       = acc_q[11:0] & glzw_pkg::code_mask(size_q);
	assign is_clear   = (code == clear_code);
	assign is_eoi     = (code == clear_code + 12'd1);
	assign kwk        = ({1'b0, code} >= nfc_q);
	assign start_cur  = kwk ? prev_q : code;
	assign prefix     = dict_rdata[19:8];
	assign stack_full = (cnt_q >= CW'(STACK_DEPTH));
	assign avail      = (written_q < total_q) ? (total_q - written_q) : 32'd0;
	assign bud_sum    = BW'(res_count_q)
		+ ((BW'(fill_q) + BW'(kept_q)) >> glzw_pkg::GROUP_AW) + BW'(1);
	assign bud_fail   = (bud_sum > BW'(glzw_pkg::MAX_RESULTS));
	assign nfc_new    = (nfc_q < 13'(glzw_pkg::DICT_ENTRIES)) ? nfc_q + 13'd1 : nfc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			glzw_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (!raster.start_image && finished_q) ?
						glzw_pkg::ST_PUT_LAST : glzw_pkg::ST_NEXT;
				end
			end
			glzw_pkg::ST_NEXT: begin
				priority if (!have_code) state_d = glzw_pkg::ST_PUT_LAST;
				else if (is_clear || is_eoi) state_d = glzw_pkg::ST_NEXT;
				else if (after_clear_q) state_d = glzw_pkg::ST_FINAL;
				else if (start_cur > lit_mask) state_d = glzw_pkg::ST_WALK_RD;
				else state_d = glzw_pkg::ST_FINAL;
			end
			glzw_pkg::ST_WALK_RD: state_d = glzw_pkg::ST_WALK;
			glzw_pkg::ST_WALK: begin
				priority if (stack_full) state_d = glzw_pkg::ST_NEXT;
				else if (prefix > lit_mask) state_d = glzw_pkg::ST_WALK;
				else state_d = glzw_pkg::ST_FINAL;
			end
			glzw_pkg::ST_FINAL:
				state_d = stack_full ? glzw_pkg::ST_NEXT : glzw_pkg::ST_DELIVER;
			glzw_pkg::ST_DELIVER: state_d = glzw_pkg::ST_CHECK;
			glzw_pkg::ST_CHECK: begin
				priority if (bud_fail) state_d = glzw_pkg::ST_NEXT;
				else if (kept_q == '0) state_d = glzw_pkg::ST_POST;
				else state_d = glzw_pkg::ST_POP_RD;
			end
			glzw_pkg::ST_POP_RD: state_d = glzw_pkg::ST_POP;
			glzw_pkg::ST_POP: begin
				priority if (fill_q == 6'(glzw_pkg::GROUP_PIXELS - 1))
					state_d = glzw_pkg::ST_PUT_FULL;
				else if (rem_q == CW'(1)) state_d = glzw_pkg::ST_POST;
				else state_d = glzw_pkg::ST_POP;
			end
			glzw_pkg::ST_PUT_FULL: begin
				if (out_free) begin
					state_d = (rem_q == '0) ? glzw_pkg::ST_POST : glzw_pkg::ST_POP_RD;
				end
			end
			glzw_pkg::ST_POST: state_d = glzw_pkg::ST_NEXT;
			glzw_pkg::ST_PUT_LAST: begin
				if (out_free) state_d = glzw_pkg::ST_IDLE;
			end
			default: state_d = glzw_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		dict_we    = (state_q == glzw_pkg::ST_POST) && !lit_q
			&& (nfc_q < 13'(glzw_pkg::DICT_ENTRIES));
		dict_waddr = nfc_q[11:0];
		dict_wdata = {prev_q, fc_q};
		dict_raddr = (state_q == glzw_pkg::ST_WALK) ? prefix : cur_q;
		stk_we     = 1'b0;
		stk_waddr  = cnt_q[AW-1:0];
		stk_wdata  = dict_rdata[7:0];
		unique case (state_q)
			glzw_pkg::ST_NEXT: begin
				// repeated-string case pushes the old first character
				stk_we    = have_code && !is_clear && !is_eoi && !after_clear_q && kwk;
				stk_waddr = '0;
				stk_wdata = fc_q;
			end
			glzw_pkg::ST_WALK: stk_we = !stack_full;
			glzw_pkg::ST_FINAL: begin
				stk_we    = !stack_full;
				stk_wdata = 8'(cur_q & lit_mask);
			end
			default: stk_we = 1'b0;
		endcase
		stk_raddr = (state_q == glzw_pkg::ST_POP) ? ptr_q - AW'(1) : ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= glzw_pkg::ST_IDLE;
			min_code_size_q <= 4'd8;
			color_bits_q    <= 4'd8;
			image_width_q   <= 16'hFFFF;
			image_height_q  <= 16'hFFFF;
			acc_q           <= '0;
			held_q          <= '0;
			size_q          <= 4'd9;
			nfc_q           <= 13'd258;
			prev_q          <= '0;
			fc_q            <= '0;
			after_clear_q   <= 1'b1;
			finished_q      <= 1'b0;
			written_q       <= '0;
			fill_q          <= '0;
			res_count_q     <= '0;
			eoi_f_q         <= 1'b0;
			err_f_q         <= 1'b0;
			group_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (glzw_pkg::cfg_index_t'(cfg_index))
					glzw_pkg::CFG_MIN_CODE_SIZE: min_code_size_q <= cfg_data[3:0];
					glzw_pkg::CFG_COLOR_BITS:    color_bits_q    <= cfg_data[3:0];
					glzw_pkg::CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
					glzw_pkg::CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (pixels.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				glzw_pkg::ST_IDLE: begin
					if (accept) begin
						eoi_f_q     <= 1'b0;
						err_f_q     <= 1'b0;
						res_count_q <= '0;
						if (raster.start_image) begin
							size_q        <= m_eff + 4'd1;
							nfc_q         <= 13'(clear_code) + 13'd2;
							prev_q        <= '0;
							fc_q          <= '0;
							after_clear_q <= 1'b1;
							finished_q    <= 1'b0;
							written_q     <= '0;
							acc_q         <= {12'd0, raster.raster_byte};
							held_q        <= 5'd8;
						end else if (!finished_q) begin
							acc_q  <= acc_q | (20'(raster.raster_byte) << held_q);
							held_q <= held_q + 5'd8;
						end
					end
				end
				glzw_pkg::ST_NEXT: begin
					if (have_code) begin
						if (is_eoi) begin
							acc_q  <= '0;
							held_q <= '0;
						end else begin
							acc_q  <= acc_q >> size_q;
							held_q <= held_q - {1'b0, size_q};
						end
						priority if (is_clear) begin
							size_q        <= m_eff + 4'd1;
							nfc_q         <= 13'(clear_code) + 13'd2;
							after_clear_q <= 1'b1;
						end else if (is_eoi) begin
							finished_q <= 1'b1;
							eoi_f_q    <= 1'b1;
						end else if (after_clear_q) begin
							lit_q         <= 1'b1;
							code_q        <= code;
							cur_q         <= code;
							cnt_q         <= '0;
							after_clear_q <= 1'b0;
						end else begin
							lit_q  <= 1'b0;
							code_q <= code;
							cur_q  <= start_cur;
							cnt_q  <= kwk ? CW'(1) : '0;
						end
					end
				end
				glzw_pkg::ST_WALK, glzw_pkg::ST_FINAL: begin
					if (stack_full) begin
						finished_q <= 1'b1;
						err_f_q    <= 1'b1;
						acc_q      <= '0;
						held_q     <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						if (state_q == glzw_pkg::ST_WALK) cur_q <= prefix;
						else fc_q <= 8'(cur_q & lit_mask);
					end
				end
				glzw_pkg::ST_DELIVER: begin
					kept_q <= (32'(cnt_q) < avail) ? cnt_q : CW'(avail);
				end
				glzw_pkg::ST_CHECK: begin
					if (bud_fail) begin
						finished_q <= 1'b1;
						err_f_q    <= 1'b1;
						acc_q      <= '0;
						held_q     <= '0;
					end else begin
						ptr_q <= AW'(cnt_q - CW'(1));
						rem_q <= kept_q;
					end
				end
				glzw_pkg::ST_POP: begin
					group_q[fill_q[glzw_pkg::GROUP_AW-1:0]] <= stk_rdata;
					fill_q    <= fill_q + 6'd1;
					written_q <= written_q + 32'd1;
					rem_q     <= rem_q - CW'(1);
					ptr_q     <= ptr_q - AW'(1);
				end
				glzw_pkg::ST_PUT_FULL: begin
					if (out_free) begin
						out_group_q <= group_q;
						out_count_q <= 6'(glzw_pkg::GROUP_PIXELS);
						out_last_q  <= 1'b0;
						out_eoi_q   <= 1'b0;
						out_err_q   <= 1'b0;
						group_q     <= '0;
						fill_q      <= '0;
						res_count_q <= res_count_q + 6'd1;
					end
				end
				glzw_pkg::ST_POST: begin
					prev_q <= code_q;
					if (!lit_q) begin
						nfc_q <= nfc_new;
						if ((nfc_new >= (13'd1 << size_q))
							&& (size_q < 4'(glzw_pkg::MAX_CODE_BITS))) begin
							size_q <= size_q + 4'd1;
						end
					end
				end
				glzw_pkg::ST_PUT_LAST: begin
					if (out_free) begin
						out_group_q <= group_q;
						out_count_q <= fill_q;
						out_last_q  <= 1'b1;
						out_eoi_q   <= eoi_f_q;
						out_err_q   <= err_f_q;
						group_q     <= '0;
						fill_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// pixel total follows the live size registers
	always_ff @(posedge clk) begin
		total_q <= 32'(image_width_q) * 32'(image_height_q);
	end

	assign pixels.valid          = out_valid_q;
	assign pixels.pixels_group_a = out_group_q[7:0];
	assign pixels.pixels_group_b = out_group_q[15:8];
	assign pixels.pixels_group_c = out_group_q[23:16];
	assign pixels.pixels_group_d = out_group_q[31:24];
	assign pixels.pixel_count    = out_count_q;
	assign pixels.last_of_run    = out_last_q;
	assign pixels.end_of_image   = out_eoi_q;
	assign pixels.error_code     = out_err_q;
endmodule

### dv/glzw_checker.sv
// checker for the gif lzw pixel decoder: predicts pixel results per byte and compares them
module glzw_checker
	import glzw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	glzw_raster_if            raster,
	glzw_pixel_if             pixels,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output int                errors,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [63:0] grp_a;
		logic [63:0] grp_b;
		logic [63:0] grp_c;
		logic [63:0] grp_d;
		logic [5:0]  count;
		logic        last;
		logic        eoi;
		logic        err;
	} pixel_result_t;

	pixel_result_t expected_groups[$];

	logic [11:0] prefix_mem[DICT_ENTRIES];
	logic [7:0]  suffix_mem[DICT_ENTRIES];
	logic [7:0]  chain_stack[STACK_DEPTH_DEF];
	logic [7:0]  group_pix[GROUP_PIXELS];

	int unsigned reg_min, reg_bits, reg_width, reg_height;
	int unsigned acc_bits, held_bits, code_size, free_code, prev_code, first_pix;
	int unsigned pix_done, result_cnt, group_fill;
	bit          just_cleared, stopped;

	function automatic int unsigned min_size();
		return reg_min < 2 ? 2 : (reg_min > 8 ? 8 : reg_min);
	endfunction

	function automatic int unsigned pix_bits();
		return reg_bits < 1 ? 1 : (reg_bits > 8 ? 8 : reg_bits);
	endfunction

	function automatic void restart_image();
		acc_bits     = 0;
		held_bits    = 0;
		code_size    = min_size() + 1;
		free_code    = (1 << min_size()) + 2;
		prev_code    = 0;
		first_pix    = 0;
		just_cleared = 1;
		stopped      = 0;
		pix_done     = 0;
	endfunction

	function automatic void emit_group(bit last, bit eoi, bit err);
		pixel_result_t r;
		logic [255:0]  flat;
		if (result_cnt >= MAX_RESULTS) return;
		flat = '0;
		for (int i = 0; i < group_fill; i++) flat[i*8 +: 8] = group_pix[i];
		r.grp_a = flat[63:0];
		r.grp_b = flat[127:64];
		r.grp_c = flat[191:128];
		r.grp_d = flat[255:192];
		r.count = 6'(group_fill);
		r.last  = last;
		r.eoi   = eoi;
		r.err   = err;
		expected_groups.push_back(r);
		result_cnt++;
		group_fill = 0;
	endfunction

	// pops up to n stacked pixels in raster order; 0 when the result budget would burst
	function automatic bit pop_pixels(int unsigned n);
		int unsigned total, avail, kept;
		total = reg_width * reg_height;
		avail = pix_done < total ? total - pix_done : 0;
		kept  = n < avail ? n : avail;
		if (result_cnt + (group_fill + kept) / GROUP_PIXELS + 1 > MAX_RESULTS) return 0;
		for (int unsigned i = n; i > 0; i--) begin
			if (pix_done >= total) break;
			group_pix[group_fill] = chain_stack[i-1];
			group_fill++;
			pix_done++;
			if (group_fill >= GROUP_PIXELS) emit_group(0, 0, 0);
		end
		return 1;
	endfunction

	// 0 ok, 1 end of information, 2 overflow
	function automatic int decode_code(int unsigned code);
		int unsigned clr, mask, cur, cnt;
		clr  = 1 << min_size();
		mask = (1 << pix_bits()) - 1;
		cnt  = 0;
		if (code == clr) begin
			code_size    = min_size() + 1;
			free_code    = clr + 2;
			just_cleared = 1;
			return 0;
		end
		if (code == clr + 1) return 1;
		if (just_cleared) begin
			just_cleared = 0;
			prev_code = code;
			first_pix = code & mask;
			chain_stack[0] = 8'(first_pix);
			return pop_pixels(1) ? 0 : 2;
		end
		cur = code;
		// code not yet in the table
		if (cur >= free_code) begin
			cur = prev_code;
			chain_stack[cnt] = 8'(first_pix);
			cnt++;
		end
		while (cur > mask) begin
			if (cnt >= STACK_DEPTH_DEF) return 2;
			cur &= DICT_ENTRIES - 1;
			chain_stack[cnt] = suffix_mem[cur];
			cnt++;
			cur = prefix_mem[cur];
		end
		if (cnt >= STACK_DEPTH_DEF) return 2;
		first_pix = cur & mask;
		chain_stack[cnt] = 8'(first_pix);
		cnt++;
		if (!pop_pixels(cnt)) return 2;
		if (free_code < DICT_ENTRIES) begin
			prefix_mem[free_code] = 12'(prev_code);
			suffix_mem[free_code] = 8'(first_pix);
			free_code++;
		end
		prev_code = code;
		if (free_code >= (1 << code_size) && code_size < MAX_CODE_BITS) code_size++;
		return 0;
	endfunction

	function automatic void decode_byte(logic [7:0] data, logic restart);
		bit          eoi, err;
		int unsigned code;
		int          status;
		eoi = 0;
		err = 0;
		result_cnt = 0;
		group_fill = 0;
		if (restart) restart_image();
		if (!stopped) begin
			acc_bits |= int'(data) << held_bits;
			held_bits += 8;
			while (!stopped && held_bits >= code_size) begin
				code = acc_bits & ((1 << code_size) - 1);
				acc_bits >>= code_size;
				held_bits -= code_size;
				status = decode_code(code);
				if (status != 0) begin
					stopped = 1;
					acc_bits = 0;
					held_bits = 0;
					if (status == 1) eoi = 1;
					else err = 1;
				end
			end
			acc_bits &= 32'hFFFFF;
		end
		emit_group(1, eoi, err);
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		if (!arst_n) begin
			reg_min = 8;
			reg_bits = 8;
			reg_width = 65535;
			reg_height = 65535;
			restart_image();
			expected_groups.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_CODE_SIZE: reg_min    = cfg_data[3:0];
					CFG_COLOR_BITS:    reg_bits   = cfg_data[3:0];
					CFG_IMAGE_WIDTH:   reg_width  = cfg_data;
					CFG_IMAGE_HEIGHT:  reg_height = cfg_data;
					default: ;
				endcase
			end
			if (raster.valid && raster.ready) decode_byte(raster.raster_byte, raster.start_image);
			if (pixels.valid && pixels.ready) begin
				if (expected_groups.size() == 0) begin
					$error("pixel result with nothing expected");
					errors++;
				end else begin
					want = expected_groups.pop_front();
					check_field("pixels_group_a", want.grp_a, pixels.pixels_group_a);
					check_field("pixels_group_b", want.grp_b, pixels.pixels_group_b);
					check_field("pixels_group_c", want.grp_c, pixels.pixels_group_c);
					check_field("pixels_group_d", want.grp_d, pixels.pixels_group_d);
					check_field("pixel_count", 64'(want.count), 64'(pixels.pixel_count));
					check_field("last_of_run", 64'(want.last), 64'(pixels.last_of_run));
					check_field("end_of_image", 64'(want.eoi), 64'(pixels.end_of_image));
					check_field("error_code", 64'(want.err), 64'(pixels.error_code));
				end
			end
		end
		outstanding = expected_groups.size();
	end

endmodule

### dv/tb_top.sv
// top of the gif lzw pixel decoder testbench: clock, reset, lzw stream stimulus and verdict
module tb_top;
	import glzw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	int                errors;
	int                outstanding;
	int                quiet_cycles;
	bit                no_idle;

	glzw_raster_if raster ();
	glzw_pixel_if  pixels ();

	gif_lzw_pixel_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raster    (raster),
		.pixels    (pixels),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	glzw_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.raster      (raster),
		.pixels      (pixels),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(negedge clk) begin
		pixels.ready <= arst_n && (no_idle || $urandom_range(99) >= 11);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((raster.valid && raster.ready) || (pixels.valid && pixels.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// lzw stream builder: mirrors the code size and free code of the decoder
	logic [31:0] bit_buf;
	int unsigned buf_bits, gen_min, gen_clear, gen_size, gen_free, lit_top, bytes_sent;
	bit          gen_after_clear, first_byte;

	task automatic send_byte(logic [7:0] data);
		while (!no_idle && $urandom_range(99) < 11) begin
			raster.valid <= 0;
			@(negedge clk);
		end
		raster.valid       <= 1;
		raster.raster_byte <= data;
		raster.start_image <= first_byte;
		first_byte = 0;
		do @(posedge clk); while (!raster.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		raster.valid <= 0;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_regs(int unsigned m, int unsigned b, int unsigned w, int unsigned h);
		logic [CFG_DW-1:0] vals[4];
		cfg_index_t        idx[4];
		vals = '{CFG_DW'(m), CFG_DW'(b), CFG_DW'(w), CFG_DW'(h)};
		idx  = '{CFG_MIN_CODE_SIZE, CFG_COLOR_BITS, CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 0;
		gen_min = m < 2 ? 2 : (m > 8 ? 8 : m);
		gen_clear = 1 << gen_min;
		lit_top = (1 << (b < 1 ? 1 : (b > 8 ? 8 : b))) - 1;
		if (lit_top > gen_clear - 1) lit_top = gen_clear - 1;
	endtask

	task automatic begin_image();
		bit_buf = 0;
		buf_bits = 0;
		first_byte = 1;
		gen_size = gen_min + 1;
		gen_free = gen_clear + 2;
		gen_after_clear = 1;
	endtask

	task automatic put_code(int unsigned code);
		bit_buf |= code << buf_bits;
		buf_bits += gen_size;
		while (buf_bits >= 8) begin
			send_byte(bit_buf[7:0]);
			bit_buf >>= 8;
			buf_bits -= 8;
		end
		if (code == gen_clear) begin
			gen_size = gen_min + 1;
			gen_free = gen_clear + 2;
			gen_after_clear = 1;
		end else if (code != gen_clear + 1) begin
			if (gen_after_clear) gen_after_clear = 0;
			else begin
				if (gen_free < DICT_ENTRIES) gen_free++;
				if (gen_free >= (1 << gen_size) && gen_size < MAX_CODE_BITS) gen_size++;
			end
		end
	endtask

	task automatic flush_bits(bit random_pad);
		logic [7:0] pad;
		pad = random_pad ? 8'($urandom) : 8'h00;
		if (buf_bits > 0) send_byte(bit_buf[7:0] | 8'(pad << buf_bits));
		bit_buf = 0;
		buf_bits = 0;
	endtask

	// literals, written codes, the next free code or a clear; after a clear only literals
	function automatic int unsigned pick_code(int lit_w, int dict_w, int kwk_w, bit clears);
		int r;
		r = $urandom_range(99);
		if (gen_after_clear) return $urandom_range(lit_top);
		if (r < lit_w) return $urandom_range(3) == 0 ? ($urandom_range(1) ? lit_top : 0)
			: $urandom_range(lit_top);
		if (r < lit_w + dict_w && gen_free > gen_clear + 2)
			return $urandom_range(gen_free - 1, gen_clear + 2);
		if (r < lit_w + dict_w + kwk_w && gen_free < DICT_ENTRIES) return gen_free;
		if (clears && r >= 96) return gen_clear;
		return $urandom_range(lit_top);
	endfunction

	task automatic random_image(int codes);
		bit with_eoi;
		with_eoi = $urandom_range(3) != 0;
		begin_image();
		if ($urandom_range(1)) put_code(gen_clear);
		repeat (codes) put_code(pick_code(45, 35, 10, 1));
		if (with_eoi) begin
			put_code(gen_clear + 1);
			flush_bits(1);
			repeat ($urandom_range(2)) send_byte(8'($urandom));
		end else
			flush_bits(0);
	endtask

	function automatic int unsigned rand_reg4(int unsigned lo, int unsigned hi);
		return $urandom_range(5) == 0 ? $urandom_range(15) : $urandom_range(hi, lo);
	endfunction

	function automatic int unsigned rand_dim();
		int r;
		r = $urandom_range(19);
		if (r == 0) return 0;
		if (r == 1) return 65535;
		if (r < 4) return $urandom_range(65535);
		return $urandom_range(12, 1);
	endfunction

	initial begin
		int img;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_MIN_CODE_SIZE;
		cfg_data = 0;
		raster.valid = 0;
		raster.raster_byte = 0;
		raster.start_image = 0;
		pixels.ready = 0;
		no_idle = 0;
		quiet_cycles = 0;
		bytes_sent = 0;
		first_byte = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// small codes, pixel cutoff, dictionary hit, code not yet in table, clear after clear
		set_regs(2, 2, 3, 2);
		begin_image();
		put_code(gen_clear);
		put_code(0);
		put_code(3);
		put_code(6);
		put_code(gen_free);
		put_code(gen_clear);
		put_code(gen_clear);
		put_code(2);
		put_code(gen_clear + 1);
		flush_bits(1);
		send_byte(8'hFF);

		// widest literals, then end of information right after a clear
		set_regs(8, 8, 65535, 65535);
		begin_image();
		put_code(255);
		put_code(0);
		put_code(gen_free);
		put_code(gen_clear);
		put_code(gen_clear + 1);
		flush_bits(1);
		send_byte(8'h00);

		// out-of-range registers saturate, zero size drops all pixels
		set_regs(15, 0, 0, 0);
		begin_image();
		put_code(1);
		put_code(0);
		put_code(gen_clear + 1);
		flush_bits(1);

		img = 0;
		while (bytes_sent < 430) begin
			if (img % 3 == 0) set_regs(rand_reg4(2, 8), rand_reg4(1, 8), rand_dim(), rand_dim());
			no_idle = img >= 6 && img < 12;
			random_image($urandom_range(40, 1));
			img++;
		end
		no_idle = 0;

		wait_idle();
		repeat (30) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
design/glzw_pkg.sv
design/glzw_if.sv
design/glzw_ram.sv
design/gif_lzw_pixel_decoder.sv
dv/glzw_checker.sv
dv/tb_top.sv
